// ===== rtl/core/rda_pkg.sv =====
`default_nettype none
package rda_pkg;
    localparam int CordicSteps = 16;
    localparam logic signed [39:0] Q32Pi = 40'sh03243F6A89;
    localparam logic signed [39:0] Q32TwoPi = 40'sh06487ED511;
    localparam logic signed [39:0] Q32HalfPi = 40'sh01921FB544;
    localparam logic signed [39:0] Q32Gain = 40'sh009B74EDA8;

    localparam logic [1:0] CompU = 2'd0;
    localparam logic [1:0] CompV = 2'd1;
    localparam logic [1:0] CompW = 2'd2;
    localparam logic [1:0] CompNone = 2'd3;

    localparam logic [2:0] RegAxisX = 3'd0;
    localparam logic [2:0] RegAxisY = 3'd1;
    localparam logic [2:0] RegAxisZ = 3'd2;
    localparam logic [2:0] RegCenterX = 3'd3;
    localparam logic [2:0] RegCenterY = 3'd4;
    localparam logic [2:0] RegCenterZ = 3'd5;
    localparam logic [2:0] RegDim = 3'd6;

    // atan(2^-i) in Q.32, rounded.
    function automatic logic signed [39:0] f_arc(input logic [5:0] i);
        logic signed [39:0] v;
        unique case (i)
            6'd0: v = 40'sh00C90FDAA2;
            6'd1: v = 40'sh0076B19C16;
            6'd2: v = 40'sh003EB6EBF2;
            6'd3: v = 40'sh001FD5BA9B;
            6'd4: v = 40'sh000FFAADDC;
            6'd5: v = 40'sh0007FF556F;
            6'd6: v = 40'sh0003FFEAAB;
            6'd7: v = 40'sh0001FFFD55;
            6'd8: v = 40'sh0000FFFFAB;
            6'd9: v = 40'sh00007FFFF5;
            6'd10: v = 40'sh00003FFFFF;
            6'd11: v = 40'sh0000200000;
            6'd12: v = 40'sh0000100000;
            6'd13: v = 40'sh0000080000;
            6'd14: v = 40'sh0000040000;
            6'd15: v = 40'sh0000020000;
            6'd16: v = 40'sh0000010000;
            6'd17: v = 40'sh0000008000;
            6'd18: v = 40'sh0000004000;
            6'd19: v = 40'sh0000002000;
            6'd20: v = 40'sh0000001000;
            6'd21: v = 40'sh0000000800;
            6'd22: v = 40'sh0000000400;
            6'd23: v = 40'sh0000000200;
            6'd24: v = 40'sh0000000100;
            6'd25: v = 40'sh0000000080;
            6'd26: v = 40'sh0000000040;
            6'd27: v = 40'sh0000000020;
            6'd28: v = 40'sh0000000010;
            6'd29: v = 40'sh0000000008;
            6'd30: v = 40'sh0000000004;
            6'd31: v = 40'sh0000000002;
            default: v = 40'sh0000000001;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/rotation_displacement_about_axis.sv =====
`default_nettype none
// Rodrigues rotation displacement about a configured axis and center.
// Input: pulse start with angle, point and component while busy is low;
// busy is always low, so one beat may be taken every cycle.
// Output: o_valid is high for exactly one cycle with o_displacement and
// o_saturated; the receiver cannot stall, so results are never held.
// From the accepting edge a beat passes the angle-reduction registers, then the
// chain of CORDIC cells, one per step (CORDIC_STEPS, capped at 32), then the
// back-end registers for rounding, axis products, the matrix row, the split
// displacement, the products, the sum, and the output register with the clamp.
// Throughput is one beat per cycle, set by the pipelined cell chain.
// The user must write configuration over the APB port only while no beat is in flight; the block does not enforce it.
// Synchronous reset empties the pipeline and restores axis (0,0,32767),
// center zero and dimension three.
// Selector three or a component beyond the dimension gives zero.
module rotation_displacement_about_axis import rda_pkg::*; #(
    parameter int CORDIC_STEPS = CordicSteps
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        start,
    output logic       busy,
    input  wire signed [31:0] i_angle,
    input  wire signed [31:0] i_pos_x,
    input  wire signed [31:0] i_pos_y,
    input  wire signed [31:0] i_pos_z,
    input  wire [1:0]  i_component,
    output logic       o_valid,
    output logic signed [31:0] o_displacement,
    output logic       o_saturated,
    input  wire        psel,
    input  wire        penable,
    input  wire        pwrite,
    input  wire [4:0]  paddr,
    input  wire [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready
);
    localparam int NSteps = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int Pre = 3;
    localparam int Lat = Pre + NSteps;

    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] dz;
        logic [1:0] comp;
        logic zero;
    } t_side;

    logic signed [15:0] r_ax, r_ay, r_az;
    logic signed [31:0] r_cx, r_cy, r_cz;
    logic [1:0] r_dim;
    logic w_wr;
    logic [2:0] w_reg;

    assign busy = 1'b0;
    assign pready = 1'b1;
    assign w_wr = psel && penable && pwrite;
    assign w_reg = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax <= '0; r_ay <= '0; r_az <= 16'sd32767;
            r_cx <= '0; r_cy <= '0; r_cz <= '0; r_dim <= 2'd3;
        end else if (w_wr) begin
            unique case (w_reg)
                RegAxisX: r_ax <= pwdata[15:0];
                RegAxisY: r_ay <= pwdata[15:0];
                RegAxisZ: r_az <= pwdata[15:0];
                RegCenterX: r_cx <= pwdata;
                RegCenterY: r_cy <= pwdata;
                RegCenterZ: r_cz <= pwdata;
                RegDim: r_dim <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            RegAxisX: prdata = {{16{r_ax[15]}}, r_ax};
            RegAxisY: prdata = {{16{r_ay[15]}}, r_ay};
            RegAxisZ: prdata = {{16{r_az[15]}}, r_az};
            RegCenterX: prdata = r_cx;
            RegCenterY: prdata = r_cy;
            RegCenterZ: prdata = r_cz;
            RegDim: prdata = {30'd0, r_dim};
            default: prdata = '0;
        endcase
    end

    // Angle reduction: stage 0 estimates the quotient by 2pi with a constant
    // multiplication. |angle*2^16| <= 2^47; subtract 2pi multiples from it.
    logic signed [48:0] w_a;
    logic signed [39:0] r_p0;
    logic signed [16:0] w_q;
    logic signed [67:0] w_qm;
    logic signed [48:0] r_a0;
    logic signed [16:0] r_q0;
    logic signed [39:0] n_r1;
    logic signed [39:0] r_r1, r_r2;
    logic r_neg2, n_neg;
    logic signed [39:0] n_r2;
    logic [Pre-1:0] r_pv;
    t_side n_side;
    t_side r_sd [Pre];

    assign w_a = 49'(i_angle) <<< 16;
    // Quotient estimate: angle * (2^16/2pi) >> 32, off by at most one.
    assign w_q = 17'((64'(signed'(i_angle)) * 64'sd10430) >>> 32);

    always_comb begin
        n_side.dx = (r_dim >= 2'd1) ? 33'(i_pos_x) - 33'(r_cx) : '0;
        n_side.dy = (r_dim >= 2'd2) ? 33'(i_pos_y) - 33'(r_cy) : '0;
        n_side.dz = (r_dim >= 2'd3) ? 33'(i_pos_z) - 33'(r_cz) : '0;
        n_side.comp = i_component;
        n_side.zero = (i_component == CompNone) || ({1'b0, i_component} >= {1'b0, r_dim});
    end

    assign w_qm = 68'(r_q0) * 68'(Q32TwoPi);

    always_comb begin
        logic signed [49:0] t;
        t = 50'(r_a0) - 50'(w_qm);
        // Bring the estimate to the remainder truncated toward zero.
        if (!r_a0[48] && t >= 50'(Q32TwoPi)) t = t - 50'(Q32TwoPi);
        else if (!r_a0[48] && t < 0) t = t + 50'(Q32TwoPi);
        else if (r_a0[48] && t <= -50'(Q32TwoPi)) t = t + 50'(Q32TwoPi);
        else if (r_a0[48] && t > 0) t = t - 50'(Q32TwoPi);
        if (t < 0) t = t + 50'(Q32TwoPi);
        if (t > 50'(Q32Pi)) t = t - 50'(Q32TwoPi);
        n_r1 = 40'(t);
    end

    always_comb begin
        n_neg = 1'b0;
        n_r2 = r_r1;
        if (r_r1 > Q32HalfPi) begin
            n_r2 = r_r1 - Q32Pi; n_neg = 1'b1;
        end else if (r_r1 < -Q32HalfPi) begin
            n_r2 = r_r1 + Q32Pi; n_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pv <= '0;
        else r_pv <= {r_pv[Pre-2:0], start};
        r_a0 <= w_a;
        r_q0 <= w_q;
        r_r1 <= n_r1;
        r_r2 <= n_r2;
        r_neg2 <= n_neg;
        r_sd[0] <= n_side;
        for (int k = 1; k < Pre; k++) r_sd[k] <= r_sd[k-1];
    end
    assign r_p0 = r_r2;

    // CORDIC cell chain.
    logic signed [39:0] c_x [NSteps+1];
    logic signed [39:0] c_y [NSteps+1];
    logic signed [39:0] c_r [NSteps+1];
    logic c_v [NSteps+1];
    t_side r_cs [NSteps];
    logic r_cn [NSteps];

    assign c_x[0] = Q32Gain;
    assign c_y[0] = '0;
    assign c_r[0] = r_p0;
    assign c_v[0] = r_pv[Pre-1];

    for (genvar g = 0; g < NSteps; g++) begin : g_cell
        rda_cell #(.Step(g)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(c_v[g]),
            .i_x(c_x[g]), .i_y(c_y[g]), .i_r(c_r[g]),
            .o_vld(c_v[g+1]), .o_x(c_x[g+1]), .o_y(c_y[g+1]), .o_r(c_r[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        r_cs[0] <= r_sd[Pre-1];
        r_cn[0] <= r_neg2;
        for (int k = 1; k < NSteps; k++) begin
            r_cs[k] <= r_cs[k-1];
            r_cn[k] <= r_cn[k-1];
        end
    end

    // Back end: sin/cos, row of R, dot product, saturation.
    logic signed [39:0] w_xf, w_yf;
    logic signed [31:0] r_c30, r_s30;
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    t_side r_b1, r_b2, r_b3, r_b4;
    t_side r_b4p;
    assign w_xf = r_cn[NSteps-1] ? -c_x[NSteps] : c_x[NSteps];
    assign w_yf = r_cn[NSteps-1] ? -c_y[NSteps] : c_y[NSteps];

    logic signed [15:0] w_nc;
    logic signed [15:0] r_n0, r_n1, r_n2;
    logic signed [31:0] r_nn [3];
    logic signed [31:0] r_c2, r_s2, r_c3;
    logic signed [32:0] r_omc;
    logic signed [47:0] r_ns [3];
    logic signed [32:0] r_row [3];
    logic signed [32:0] r_dh [3];
    logic signed [15:0] r_dl [3];
    logic signed [65:0] r_ph [3];
    logic signed [49:0] r_pl [3];
    logic signed [63:0] r_v;
    logic r_zero5;

    always_comb begin
        unique case (r_b1.comp)
            CompU: w_nc = r_ax;
            CompV: w_nc = r_ay;
            default: w_nc = r_az;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0;
            r_v4 <= 1'b0; r_v5 <= 1'b0; r_v6 <= 1'b0;
        end else begin
            r_v1 <= c_v[NSteps]; r_v2 <= r_v1; r_v3 <= r_v2;
            r_v4 <= r_v3; r_v5 <= r_v4; r_v6 <= r_v5;
        end
        // Stage 1: round sin and cos to Q2.30.
        r_c30 <= 32'((w_xf + 40'sd2) >>> 2);
        r_s30 <= 32'((w_yf + 40'sd2) >>> 2);
        r_b1 <= r_cs[NSteps-1];
        // Stage 2: axis products.
        r_n0 <= r_ax; r_n1 <= r_ay; r_n2 <= r_az;
        r_nn[0] <= 32'(w_nc * r_ax);
        r_nn[1] <= 32'(w_nc * r_ay);
        r_nn[2] <= 32'(w_nc * r_az);
        r_c2 <= r_c30; r_s2 <= r_s30;
        r_omc <= 33'sd1073741824 - 33'(r_c30);
        r_b2 <= r_b1;
        // Stage 3: matrix row terms.
        for (int j = 0; j < 3; j++)
            r_row[j] <= 33'((64'(r_nn[j]) * 64'(r_omc)) >>> 30);
        r_ns[0] <= 48'(r_n0 * r_s2) >>> 15;
        r_ns[1] <= 48'(r_n1 * r_s2) >>> 15;
        r_ns[2] <= 48'(r_n2 * r_s2) >>> 15;
        r_b3 <= r_b2;
        r_c3 <= r_c2;
    end

    logic signed [32:0] n_row [3];
    always_comb begin
        for (int j = 0; j < 3; j++) n_row[j] = r_row[j];
        unique case (r_b3.comp)
            CompU: begin
                n_row[0] = n_row[0] + 33'(r_c3);
                n_row[1] = n_row[1] - 33'(r_ns[2]);
                n_row[2] = n_row[2] + 33'(r_ns[1]);
            end
            CompV: begin
                n_row[1] = n_row[1] + 33'(r_c3);
                n_row[0] = n_row[0] + 33'(r_ns[2]);
                n_row[2] = n_row[2] - 33'(r_ns[0]);
            end
            default: begin
                n_row[2] = n_row[2] + 33'(r_c3);
                n_row[0] = n_row[0] - 33'(r_ns[1]);
                n_row[1] = n_row[1] + 33'(r_ns[0]);
            end
        endcase
    end

    logic signed [32:0] r_rw [3];
    logic signed [32:0] w_d3 [3];
    assign w_d3[0] = r_b3.dx;
    assign w_d3[1] = r_b3.dy;
    assign w_d3[2] = r_b3.dz;

    logic signed [67:0] w_sh, w_sl;
    logic signed [67:0] w_hq, w_rem, w_t;
    logic signed [67:0] w_vv;
    logic signed [32:0] w_dc;
    always_comb begin
        w_sh = 68'(r_ph[0]) + 68'(r_ph[1]) + 68'(r_ph[2]);
        w_sl = 68'(r_pl[0]) + 68'(r_pl[1]) + 68'(r_pl[2]);
        w_hq = w_sh >>> 14;
        w_rem = w_sh - (w_hq <<< 14);
        w_t = ((w_rem <<< 16) + w_sl + 68'sd536870912) >>> 30;
        unique case (r_b4.comp)
            CompU: w_dc = r_b4.dx;
            CompV: w_dc = r_b4.dy;
            default: w_dc = r_b4.dz;
        endcase
        w_vv = w_hq + w_t - 68'(w_dc);
    end

    always_ff @(posedge i_clk) begin
        // Stage 4: registered row, split displacement.
        for (int j = 0; j < 3; j++) begin
            r_rw[j] <= n_row[j];
            r_dh[j] <= w_d3[j] >>> 16;
            r_dl[j] <= 16'(w_d3[j][15:0]);
        end
        r_b4p <= r_b3;
        // Stage 5: products.
        for (int j = 0; j < 3; j++) begin
            r_ph[j] <= 66'(r_rw[j]) * 66'(r_dh[j]);
            r_pl[j] <= 50'(r_rw[j]) * 50'(signed'({1'b0, r_dl[j]}));
        end
        r_b4 <= r_b4p;
        // Stage 6: sum, round and subtract; the clamp follows at the output register.
        r_zero5 <= r_b4.zero;
        r_v <= 64'(w_vv);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else o_valid <= r_v6;
    end

    logic signed [31:0] n_disp;
    logic n_sat;
    always_comb begin
        n_sat = 1'b0;
        if (r_zero5) n_disp = '0;
        else if (r_v > 64'sd2147483647) begin
            n_disp = 32'sh7FFFFFFF; n_sat = 1'b1;
        end else if (r_v < -64'sd2147483648) begin
            n_disp = 32'sh80000000; n_sat = 1'b1;
        end else n_disp = 32'(r_v);
    end

    always_ff @(posedge i_clk) begin
        o_displacement <= n_disp;
        o_saturated <= n_sat;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_saturated && o_displacement != 32'sh7FFFFFFF
                      && o_displacement != 32'sh80000000))
        else $error("saturation flag without clamped value");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v6 |=> o_valid)
        else $error("result beat lost at output");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(r_zero5)) |-> (o_displacement == '0 && !o_saturated))
        else $error("unused component gave nonzero result");
endmodule
`default_nettype wire

// ===== rtl/core/rda_cell.sv =====
`default_nettype none
module rda_cell import rda_pkg::*; #(
    parameter int Step = 0
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_vld,
    input  wire signed [39:0] i_x,
    input  wire signed [39:0] i_y,
    input  wire signed [39:0] i_r,
    output logic              o_vld,
    output logic signed [39:0] o_x,
    output logic signed [39:0] o_y,
    output logic signed [39:0] o_r
);
    localparam logic [5:0] Idx = 6'(Step);
    logic signed [39:0] n_x, n_y, n_r, w_arc;

    always_comb begin
        w_arc = f_arc(Idx);
        if (!i_r[39]) begin
            n_x = i_x - (i_y >>> Step);
            n_y = i_y + (i_x >>> Step);
            n_r = i_r - w_arc;
        end else begin
            n_x = i_x + (i_y >>> Step);
            n_y = i_y - (i_x >>> Step);
            n_r = i_r + w_arc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_vld <= 1'b0;
        else o_vld <= i_vld;
        o_x <= n_x;
        o_y <= n_y;
        o_r <= n_r;
    end
endmodule
`default_nettype wire

// ===== tb/sv/tb_rotation_displacement_about_axis.sv =====
module tb_rotation_displacement_about_axis;
    import rda_pkg::*;

    localparam longint TwoPi = 64'sh6487ED511;
    localparam longint Pi = 64'sh3243F6A89;
    localparam longint HalfPi = 64'sh1921FB544;
    localparam longint QtrPi = 64'shC90FDAA2;
    localparam longint Gain = 64'sh9B74EDA8;
    localparam int PipeDepth = CordicSteps + 9;

    typedef struct packed {
        logic [31:0] disp;
        logic        sat;
    } t_disp_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic signed [31:0] i_angle, i_pos_x, i_pos_y, i_pos_z;
    logic [1:0]  i_component;
    logic        o_valid;
    logic signed [31:0] o_displacement;
    logic        o_saturated;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic signed [15:0] axis_n [3];
    logic signed [31:0] center_c [3];
    logic [1:0]  dim_cfg;

    t_disp_result pending_disp [$];
    int failures;
    int sender_idle_pct;

    rotation_displacement_about_axis dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_angle(i_angle), .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_component(i_component), .o_valid(o_valid),
        .o_displacement(o_displacement), .o_saturated(o_saturated),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic longint arctan_step(input int unsigned i);
        longint unsigned acc;
        longint unsigned term;
        int unsigned k;
        acc = 0;
        if (i == 0) begin
            return QtrPi;
        end
        for (k = 0; i * (2 * k + 1) <= 62; k++) begin
            term = (64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1);
            if (k[0]) begin
                acc -= term;
            end else begin
                acc += term;
            end
        end
        return longint'((acc + (64'd1 << 29)) >> 30);
    endfunction

    task automatic sin_cos_q30(input longint ang, output longint s30, output longint c30);
        longint r, x, y, nx;
        bit flip;
        int i;
        r = (ang * 65536) % TwoPi;
        x = Gain;
        y = 0;
        flip = 1'b0;
        if (r < 0) begin
            r += TwoPi;
        end
        if (r > Pi) begin
            r -= TwoPi;
        end
        if (r > HalfPi) begin
            r -= Pi;
            flip = 1'b1;
        end else if (r < -HalfPi) begin
            r += Pi;
            flip = 1'b1;
        end
        for (i = 0; i < CordicSteps; i++) begin
            if (r >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                r -= arctan_step(i);
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                r += arctan_step(i);
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c30 = (x + 2) >>> 2;
        s30 = (y + 2) >>> 2;
    endtask

    task automatic predict_displacement(input logic signed [31:0] ang,
                                        input logic signed [31:0] px,
                                        input logic signed [31:0] py,
                                        input logic signed [31:0] pz,
                                        input logic [1:0] comp,
                                        output t_disp_result res);
        longint n [3], d [3], row [3];
        longint s30, c30, omc, sh, sl, q, rem, v, dh, dl;
        int j;
        res = '0;
        if (comp > CompW || comp >= dim_cfg) begin
            return;
        end
        for (j = 0; j < 3; j++) begin
            n[j] = axis_n[j];
        end
        d[0] = longint'(px) - center_c[0];
        d[1] = longint'(py) - center_c[1];
        d[2] = longint'(pz) - center_c[2];
        for (j = 0; j < 3; j++) begin
            if (j >= dim_cfg) begin
                d[j] = 0;
            end
        end
        sin_cos_q30(longint'(ang), s30, c30);
        omc = (64'sd1 <<< 30) - c30;
        for (j = 0; j < 3; j++) begin
            row[j] = (n[comp] * n[j] * omc) >>> 30;
        end
        row[comp] += c30;
        case (comp)
            CompU: begin
                row[1] -= (n[2] * s30) >>> 15;
                row[2] += (n[1] * s30) >>> 15;
            end
            CompV: begin
                row[0] += (n[2] * s30) >>> 15;
                row[2] -= (n[0] * s30) >>> 15;
            end
            default: begin
                row[0] -= (n[1] * s30) >>> 15;
                row[1] += (n[0] * s30) >>> 15;
            end
        endcase
        sh = 0;
        sl = 0;
        for (j = 0; j < 3; j++) begin
            dh = d[j] >>> 16;
            dl = d[j] - dh * 65536;
            sh += row[j] * dh;
            sl += row[j] * dl;
        end
        q = sh >>> 14;
        rem = sh - q * 16384;
        v = q + ((rem * 65536 + sl + (64'sd1 <<< 29)) >>> 30) - d[comp];
        if (v > 64'sd2147483647) begin
            v = 64'sd2147483647;
            res.sat = 1'b1;
        end else if (v < -64'sd2147483648) begin
            v = -64'sd2147483648;
            res.sat = 1'b1;
        end
        res.disp = v[31:0];
    endtask

    always @(posedge i_clk) begin
        t_disp_result want;
        if (i_rst_n && o_valid) begin
            if (pending_disp.size() == 0) begin
                $error("displacement beat with no expectation: %h", o_displacement);
                failures++;
            end else begin
                want = pending_disp.pop_front();
                if (o_displacement !== want.disp) begin
                    $error("displacement: expected %h, got %h", want.disp, o_displacement);
                    failures++;
                end
                if (o_saturated !== want.sat) begin
                    $error("saturated: expected %b, got %b", want.sat, o_saturated);
                    failures++;
                end
            end
        end
    end

    task automatic send_point(input logic [31:0] ang, input logic [31:0] px,
                              input logic [31:0] py, input logic [31:0] pz,
                              input logic [1:0] comp);
        t_disp_result res;
        start <= 1'b1;
        i_angle <= ang;
        i_pos_x <= px;
        i_pos_y <= py;
        i_pos_z <= pz;
        i_component <= comp;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        predict_displacement(ang, px, py, pz, comp, res);
        pending_disp.push_back(res);
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic drain_pipeline();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_disp.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PipeDepth + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            RegAxisX: axis_n[0] = value[15:0];
            RegAxisY: axis_n[1] = value[15:0];
            RegAxisZ: axis_n[2] = value[15:0];
            RegCenterX: center_c[0] = value;
            RegCenterY: center_c[1] = value;
            RegCenterZ: center_c[2] = value;
            RegDim: dim_cfg = value[1:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(input logic [15:0] ax, input logic [15:0] ay,
                                input logic [15:0] az, input logic [31:0] cx,
                                input logic [31:0] cy, input logic [31:0] cz,
                                input logic [1:0] dim);
        drain_pipeline();
        write_reg(RegAxisX, {16'h0, ax});
        write_reg(RegAxisY, {16'h0, ay});
        write_reg(RegAxisZ, {16'h0, az});
        write_reg(RegCenterX, cx);
        write_reg(RegCenterY, cy);
        write_reg(RegCenterZ, cz);
        write_reg(RegDim, {30'h0, dim});
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(5))
            0: return $urandom_range(3) == 0 ? 32'h7FFF_FFFF :
                      ($urandom_range(1) ? 32'h8000_0000 : 32'h0);
            1, 2: return $urandom_range(8_000_000) - 4_000_000;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_reset_defaults();
        sender_idle_pct = 0;
        send_point(32'h0001_921F, 32'h0001_0000, 32'h0, 32'h0, CompU);
        send_point(32'h0001_921F, 32'h0001_0000, 32'h0, 32'h0, CompV);
        send_point(32'h0003_243F, 32'h0002_0000, 32'h0003_0000, 32'h5, CompW);
        send_point(32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, CompU);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, CompU);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, CompV);
        send_point(32'h0003_243F, 32'h7FFF_FFFF, 32'h0, 32'h0, CompU);
        send_point(32'hFFFC_DBC1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, CompV);
        send_point($urandom, $urandom, $urandom, $urandom, CompNone);
    endtask

    task automatic test_special_cases();
        set_geometry(16'h7FFF, 16'h0, 16'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 2'd1);
        send_point(32'h0001_921F, $urandom, $urandom, $urandom, CompU);
        send_point(32'h0001_921F, $urandom, $urandom, $urandom, CompV);
        send_point(32'h0001_921F, $urandom, $urandom, $urandom, CompW);
        set_geometry(16'h8000, 16'h8000, 16'h8000, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h8000_0000, 2'd2);
        send_point(32'h0003_243F, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234, CompU);
        send_point(32'h0003_243F, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234, CompV);
        send_point(32'h0003_243F, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234, CompW);
        send_point(32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, CompV);
        set_geometry(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h0, 32'h0, 32'h0, 2'd0);
        send_point(32'h0001_0000, $urandom, $urandom, $urandom, CompU);
        send_point(32'h0001_0000, $urandom, $urandom, $urandom, CompV);
    endtask

    task automatic test_random_geometry(input int phase);
        int k;
        logic [1:0] dim;
        dim = $urandom_range(3) == 0 ? 2'($urandom_range(1, 2)) : 2'd3;
        case ($urandom_range(3))
            0: set_geometry(16'h7FFF, 16'h0, 16'h0, pick_word(), pick_word(), pick_word(), dim);
            1: set_geometry(16'h49E7, 16'hB619, 16'h49E7, pick_word(), pick_word(),
                            pick_word(), dim);
            default: set_geometry(16'($urandom), 16'($urandom), 16'($urandom), pick_word(),
                                  pick_word(), pick_word(), dim);
        endcase
        case (phase % 3)
            0: sender_idle_pct = 0;
            1: sender_idle_pct = 55;
            default: sender_idle_pct = 10;
        endcase
        for (k = 0; k < 75; k++) begin
            send_point(pick_word(), pick_word(), pick_word(), pick_word(),
                       $urandom_range(7) == 0 ? CompNone : 2'($urandom_range(2)));
            if (k == 40 && phase == 1) begin
                drain_pipeline();
            end
        end
    endtask

    initial begin
        int phase;
        failures = 0;
        sender_idle_pct = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_angle = '0;
        i_pos_x = '0;
        i_pos_y = '0;
        i_pos_z = '0;
        i_component = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        axis_n[0] = 16'sd0;
        axis_n[1] = 16'sd0;
        axis_n[2] = 16'sd32767;
        center_c[0] = '0;
        center_c[1] = '0;
        center_c[2] = '0;
        dim_cfg = 2'd3;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_special_cases();
        for (phase = 0; phase < 6; phase++) begin
            test_random_geometry(phase);
        end
        drain_pipeline();
        if (failures == 0) begin
            $display("rotation_displacement_about_axis verification clean");
        end else begin
            $display("rotation_displacement_about_axis verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("rotation_displacement_about_axis verification failed");
        $finish;
    end
endmodule
